// File: sv/bcl_pkg.sv
// Package for the bounded circular list: command, status, state and cell codes.
// Used by bcl_cell and bounded_circular_list; depends on nothing.
`default_nettype none
package bcl_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND       = 3'd0,
    CMD_PREPEND      = 3'd1,
    CMD_INSERT_AT    = 3'd2,
    CMD_REMOVE_FIRST = 3'd3,
    CMD_REMOVE_LAST  = 3'd4,
    CMD_COUNT        = 3'd5,
    CMD_DUMP         = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

endpackage
`default_nettype wire

// File: sv/bcl_cell.sv
// One storage cell of the list chain; takes data from its neighbors or the new value.
// Depends on bcl_pkg for the cell operation codes.
`default_nettype none
module bcl_cell #(
  parameter int INDEX      = 0,
  parameter int VALUE_BITS = 32,
  parameter int CNT_BITS   = 5
) (
  input  wire logic                  clk,
  input  wire bcl_pkg::cell_op_t     op,
  input  wire logic [CNT_BITS-1:0]   slot,
  input  wire logic [VALUE_BITS-1:0] new_data,
  input  wire logic [VALUE_BITS-1:0] left_data,
  input  wire logic [VALUE_BITS-1:0] right_data,
  output logic      [VALUE_BITS-1:0] data
);
  import bcl_pkg::*;

  localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(INDEX);

  always_ff @(posedge clk) begin
    case (op)
      CELL_INSERT: begin
        if (IDX == slot) begin
          data <= new_data;
        end else if (IDX > slot) begin
          data <= left_data;
        end
      end
      CELL_SHIFT: begin
        data <= right_data;
      end
      CELL_ROTATE: begin
        if (IDX == slot) begin
          data <= new_data;
        end else if (IDX < slot) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/bounded_circular_list.sv
// Bounded circular list: control sequencer over a chain of bcl_cell storage cells.
// Depends on bcl_pkg and bcl_cell.
// Latency: a single-result command shows its result in the cycle after its transfer.
// In the dump state a dump loads its entries into the output register one per
// cycle as the chain rotates by one cell. A stalled output holds dumps and commands.
// Throughput: one single-result command per cycle; reset clears only count and control.
`default_nettype none
module bounded_circular_list #(
  parameter int MAX_ENTRIES = 16,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic signed [31:0] value,
  input  wire logic [4:0]  position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] entry_value,
  output logic [4:0]       entry_count,
  output logic [1:0]       status,
  output logic             last
);
  import bcl_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
  localparam int PW       = (CNT_BITS > 5) ? CNT_BITS : 5;

  state_t                state, state_next;
  logic [CNT_BITS-1:0]   count, count_next;
  logic [CNT_BITS-1:0]   remaining, remaining_next;

  cell_op_t              cell_op;
  logic [CNT_BITS-1:0]   cell_slot;
  logic [VALUE_BITS-1:0] cell_new;
  logic [VALUE_BITS-1:0] cells [MAX_ENTRIES];

  logic                  slot_free, in_fire, full, empty, load_out;
  logic [63:0]           value_wide, head_wide;
  logic [VALUE_BITS-1:0] store_value;
  logic [PW-1:0]         pos_w, cnt_w, pos_slot, pos_clamp;
  logic [CNT_BITS-1:0]   ins_slot;
  logic [31:0]           res_value;
  status_t               res_status;
  logic                  res_last;

  assign slot_free   = !out_valid || out_ready;
  assign in_ready    = (state == ST_IDLE) && slot_free;
  assign in_fire     = in_valid && in_ready;
  assign full        = (count == CNT_BITS'(MAX_ENTRIES));
  assign empty       = (count == '0);
  assign value_wide  = {32'd0, value};
  assign store_value = value_wide[VALUE_BITS-1:0];
  assign head_wide   = 64'(cells[0]);

  always_comb begin
    pos_w     = PW'(position);
    cnt_w     = PW'(count);
    pos_slot  = (pos_w <= PW'(1)) ? '0 : pos_w - PW'(1);
    pos_clamp = (pos_slot > cnt_w) ? cnt_w : pos_slot;
    ins_slot  = pos_clamp[CNT_BITS-1:0];
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = cell_new;
    end else begin : g_mid_l
      assign left_d = cells[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_d = cells[i];
    end else begin : g_mid_r
      assign right_d = cells[i+1];
    end
    bcl_cell #(
      .INDEX      (i),
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CNT_BITS)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .slot       (cell_slot),
      .new_data   (cell_new),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    cell_op        = CELL_HOLD;
    cell_slot      = count;
    cell_new       = store_value;
    load_out       = 1'b0;
    res_value      = '0;
    res_status     = STATUS_OK;
    res_last       = 1'b1;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          case (command)
            CMD_APPEND, CMD_PREPEND, CMD_INSERT_AT: begin
              if (full) begin
                res_status = STATUS_FULL;
              end else begin
                cell_op    = CELL_INSERT;
                count_next = count + CNT_BITS'(1);
                if (command == CMD_APPEND) begin
                  cell_slot = count;
                end else if (command == CMD_PREPEND) begin
                  cell_slot = '0;
                end else begin
                  cell_slot = ins_slot;
                end
              end
            end
            CMD_REMOVE_FIRST: begin
              if (empty) begin
                res_status = STATUS_EMPTY;
              end else begin
                cell_op    = CELL_SHIFT;
                count_next = count - CNT_BITS'(1);
              end
            end
            CMD_REMOVE_LAST: begin
              if (empty) begin
                res_status = STATUS_EMPTY;
              end else begin
                count_next = count - CNT_BITS'(1);
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                res_status = STATUS_EMPTY;
              end else begin
                load_out       = 1'b0;
                state_next     = ST_DUMP;
                remaining_next = count;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          load_out       = 1'b1;
          res_value      = head_wide[31:0];
          res_last       = (remaining == CNT_BITS'(1));
          cell_op        = CELL_ROTATE;
          cell_slot      = count - CNT_BITS'(1);
          cell_new       = cells[0];
          remaining_next = remaining - CNT_BITS'(1);
          if (remaining == CNT_BITS'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      entry_value <= res_value;
      entry_count <= 5'(count_next);
      status      <= res_status;
      last        <= res_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(MAX_ENTRIES))
    else $error("Entry count exceeds capacity.");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |=> count == $past(count))
    else $error("Entry count changed during a dump.");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |-> remaining != '0 && remaining <= count)
    else $error("Dump counter out of range.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> entry_count == 5'(MAX_ENTRIES))
    else $error("Full status reported with a ring that is not full.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_EMPTY |-> entry_count == 5'd0 && entry_value == 32'sd0)
    else $error("Empty status reported with entries or a value.");

endmodule
`default_nettype wire
